@@ hdl/swm_pkg.sv @@
// Shared constants and types for the sliding window median filter.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int unsigned MAX_WINDOW_DEF   = 15;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned CFG_WIDTH        = 4;
  localparam int unsigned MIN_LENGTH       = 3;
  localparam int unsigned MIN_REQUEST      = 2;

  typedef struct packed {
    logic raw_valid;
    logic comp_valid;
    logic comp_gt;
    logic del_below;
  } link_t;

endpackage

@@ hdl/swm_cell.sv @@
// One cell of the sorted chain: holds a sample and its age and takes part in evict and insert.
`timescale 1ns / 1ps

module swm_cell #(
  parameter int unsigned SW = 16,
  parameter int unsigned AW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  logic          shift_i,
  input  logic          evict_i,
  input  logic [AW-1:0] len_last_i,
  input  logic [SW-1:0] sample_i,
  input  logic [SW-1:0] up_value_i,
  input  logic [AW-1:0] up_age_i,
  input  swm_pkg::link_t up_link_i,
  input  logic [SW-1:0] dn_value_i,
  input  logic [AW-1:0] dn_age_i,
  input  swm_pkg::link_t dn_link_i,
  output logic [SW-1:0] value_o,
  output logic [AW-1:0] age_o,
  output logic [SW-1:0] comp_value_o,
  output logic [AW-1:0] comp_age_o,
  output swm_pkg::link_t link_o
);
  import swm_pkg::*;

  logic [SW-1:0] val_q, val_d;
  logic [AW-1:0] age_q, age_d;
  logic          vld_q, vld_d;
  logic          del_self, del_here;
  logic [SW-1:0] comp_val;
  logic [AW-1:0] comp_age;
  logic          comp_vld, comp_gt;

  assign del_self = evict_i & vld_q & (age_q == len_last_i);
  assign del_here = dn_link_i.del_below | del_self;
  assign comp_val = del_here ? up_value_i : val_q;
  assign comp_age = del_here ? up_age_i : age_q;
  assign comp_vld = del_here ? up_link_i.raw_valid : vld_q;
  assign comp_gt  = ~comp_vld | ($signed(comp_val) > $signed(sample_i));

  always_comb begin
    if (comp_gt) begin
      if (dn_link_i.comp_gt) begin
        val_d = dn_value_i;
        age_d = dn_age_i + AW'(1);
        vld_d = dn_link_i.comp_valid;
      end else begin
        val_d = sample_i;
        age_d = '0;
        vld_d = 1'b1;
      end
    end else begin
      val_d = comp_val;
      age_d = comp_age + AW'(1);
      vld_d = comp_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clear_i) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign value_o      = val_q;
  assign age_o        = age_q;
  assign comp_value_o = comp_val;
  assign comp_age_o   = comp_age;
  assign link_o       = '{raw_valid: vld_q, comp_valid: comp_vld, comp_gt: comp_gt,
                          del_below: del_here};

endmodule

@@ hdl/sliding_window_median.sv @@
// Top level of the sliding window median filter.
`timescale 1ns / 1ps

// Running median over the last L samples, where L is the configured window length made odd
// (below 2 gives 3) and capped at the largest odd value not above MAX_WINDOW. The samples sit
// sorted in a chain of cells; each accepted transaction evicts the oldest sample and inserts
// the new one in one update of the chain, so one transaction is taken every clock cycle while
// the output is not stalled. The accepted sample is registered in the s1 register and the
// median is read from the chain into the output register when s1 advances. Until the window has
// filled, the sample passes through with window_full_o low. A write to window_length_i restarts
// filling and must only be made while the block is idle.
module sliding_window_median #(
  parameter int unsigned MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         window_length_we_i,
  input  logic [swm_pkg::CFG_WIDTH-1:0] window_length_i,
  input  logic                         sample_valid_i,
  output logic                         sample_ready_o,
  input  logic [SAMPLE_WIDTH-1:0]      sample_i,
  output logic                         result_valid_o,
  input  logic                         result_ready_i,
  output logic [SAMPLE_WIDTH-1:0]      filtered_o,
  output logic                         window_full_o
);
  import swm_pkg::*;

  localparam int unsigned AW      = $clog2(MAX_WINDOW);
  localparam int unsigned LW      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned MAX_ODD = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;

  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [4:0]    req_norm;
  logic [AW-1:0] len_last, mid;
  logic          accept, evict;

  logic                    s1_valid_q;
  logic [SAMPLE_WIDTH-1:0] s1_sample_q;
  logic                    s1_full_q;
  logic                    s1_adv;

  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] filtered_q;
  logic                    full_q;

  logic [SAMPLE_WIDTH-1:0] cell_value [MAX_WINDOW];
  logic [AW-1:0]           cell_age   [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] comp_value [MAX_WINDOW];
  logic [AW-1:0]           comp_age   [MAX_WINDOW];
  link_t                   cell_link  [MAX_WINDOW];

  always_comb begin
    if ({1'b0, window_length_i} < 5'(MIN_REQUEST)) begin
      req_norm = 5'(MIN_LENGTH);
    end else begin
      req_norm = {1'b0, window_length_i} | 5'd1;
    end
    if (32'(req_norm) > 32'(MAX_ODD)) begin
      len_d = LW'(MAX_ODD);
    end else begin
      len_d = LW'(req_norm);
    end
  end

  assign len_last = AW'(len_q - LW'(1));
  assign mid      = AW'((len_q - LW'(1)) >> 1);

  assign s1_adv         = s1_valid_q & (~out_valid_q | result_ready_i);
  assign sample_ready_o = ~s1_valid_q | s1_adv;
  assign accept         = sample_valid_i & sample_ready_o;
  assign evict          = (fill_q == len_q);
  assign fill_d         = (fill_q < len_q) ? fill_q + LW'(1) : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= LW'(MIN_LENGTH);
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (window_length_we_i) begin
        len_q  <= len_d;
        fill_q <= '0;
      end else if (accept) begin
        fill_q <= fill_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= sample_i;
      s1_full_q   <= (fill_d == len_q);
    end
    if (s1_adv) begin
      filtered_q <= s1_full_q ? cell_value[mid] : s1_sample_q;
      full_q     <= s1_full_q;
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [SAMPLE_WIDTH-1:0] up_value, dn_value;
    logic [AW-1:0]           up_age, dn_age;
    link_t                   up_link, dn_link;

    if (i == MAX_WINDOW - 1) begin : g_top
      assign up_value = '0;
      assign up_age   = '0;
      assign up_link  = '0;
    end else begin : g_mid
      assign up_value = cell_value[i+1];
      assign up_age   = cell_age[i+1];
      assign up_link  = cell_link[i+1];
    end

    if (i == 0) begin : g_bottom
      assign dn_value = '0;
      assign dn_age   = '0;
      assign dn_link  = '0;
    end else begin : g_inner
      assign dn_value = comp_value[i-1];
      assign dn_age   = comp_age[i-1];
      assign dn_link  = cell_link[i-1];
    end

    swm_cell #(
      .SW(SAMPLE_WIDTH),
      .AW(AW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .clear_i     (window_length_we_i),
      .shift_i     (accept),
      .evict_i     (evict),
      .len_last_i  (len_last),
      .sample_i    (sample_i),
      .up_value_i  (up_value),
      .up_age_i    (up_age),
      .up_link_i   (up_link),
      .dn_value_i  (dn_value),
      .dn_age_i    (dn_age),
      .dn_link_i   (dn_link),
      .value_o     (cell_value[i]),
      .age_o       (cell_age[i]),
      .comp_value_o(comp_value[i]),
      .comp_age_o  (comp_age[i]),
      .link_o      (cell_link[i])
    );
  end

  assign result_valid_o = out_valid_q;
  assign filtered_o     = filtered_q;
  assign window_full_o  = full_q;

endmodule
